// File: rtl/integer_to_word_tokens_assert.svh
// ----------------------------------------------------------------------------
// Integer to word tokens: assertion macros
// Shared concurrent assertion forms for the integer to word tokens block.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_WORD_TOKENS_ASSERT_SVH
`define INTEGER_TO_WORD_TOKENS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2WT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2wt same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define I2WT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2wt next-cycle check failed");

`endif

// File: rtl/i2wt_pkg.sv
// ----------------------------------------------------------------------------
// Integer to word tokens package
// Widths, word codes, group codes and the control types shared by the block.
// ----------------------------------------------------------------------------
package i2wt_pkg;

  localparam int VALUE_W = 31;
  localparam int WORD_W  = 5;
  localparam int DIGITS  = 10;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int CNT_W   = $clog2(VALUE_W);

  localparam logic [WORD_W-1:0] W_ZERO      = 5'd0;
  localparam logic [WORD_W-1:0] W_TEEN_BASE = 5'd10;
  localparam logic [WORD_W-1:0] W_TENS_BASE = 5'd18;
  localparam logic [WORD_W-1:0] W_HUNDRED   = 5'd28;
  localparam logic [WORD_W-1:0] W_THOUSAND  = 5'd29;
  localparam logic [WORD_W-1:0] W_MILLION   = 5'd30;
  localparam logic [WORD_W-1:0] W_BILLION   = 5'd31;

  localparam logic [1:0] GRP_BILLION  = 2'd0;
  localparam logic [1:0] GRP_MILLION  = 2'd1;
  localparam logic [1:0] GRP_THOUSAND = 2'd2;
  localparam logic [1:0] GRP_ONES     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } ctl_state_t;

  typedef enum logic [2:0] {
    PH_HUND,
    PH_HWORD,
    PH_TENS,
    PH_UNIT,
    PH_SCALE
  } phase_t;

  typedef struct packed {
    logic       start;
    logic       shift;
    logic       load_out;
    logic [1:0] group;
    phase_t     phase;
  } i2wt_cmd_t;

  typedef struct packed {
    logic has_word;
    logic is_last;
  } i2wt_status_t;

endpackage

// File: rtl/i2wt_datapath.sv
// ----------------------------------------------------------------------------
// Integer to word tokens datapath
// Shift-and-add-three binary to decimal conversion, word selection for the
// current group and phase, and the output word register.
// ----------------------------------------------------------------------------
module i2wt_datapath
  import i2wt_pkg::*;
(
  input  logic                clk,
  input  logic [VALUE_W-1:0]  in_value,
  input  i2wt_cmd_t           cmd,
  output i2wt_status_t        status,
  output logic [WORD_W-1:0]   out_word,
  output logic                out_last
);

  logic [VALUE_W-1:0] value_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [BCD_W-1:0]   bcd_adj;
  logic [WORD_W-1:0]  out_word_r;
  logic               out_last_r;

  logic [3:0]         dig_h;
  logic [3:0]         dig_t;
  logic [3:0]         dig_u;
  logic [3:0]         gnz;
  logic               later_zero;
  logic               is_ones;
  logic               is_zero;
  logic [WORD_W-1:0]  word_sel;
  logic               has_word;
  logic               is_last;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      value_r <= in_value;
      bcd_r   <= '0;
    end else if (cmd.shift) begin
      value_r <= {value_r[VALUE_W-2:0], 1'b0};
      bcd_r   <= {bcd_adj[BCD_W-2:0], value_r[VALUE_W-1]};
    end
    if (cmd.load_out) begin
      out_word_r <= word_sel;
      out_last_r <= is_last;
    end
  end

  assign gnz[0] = |bcd_r[39:36];
  assign gnz[1] = |bcd_r[35:24];
  assign gnz[2] = |bcd_r[23:12];
  assign gnz[3] = |bcd_r[11:0];
  assign is_zero = (bcd_r == '0);
  assign is_ones = (cmd.group == GRP_ONES);

  always_comb begin
    unique case (cmd.group)
      GRP_BILLION: begin
        dig_h      = 4'd0;
        dig_t      = 4'd0;
        dig_u      = bcd_r[39:36];
        later_zero = !(gnz[1] || gnz[2] || gnz[3]);
      end
      GRP_MILLION: begin
        dig_h      = bcd_r[35:32];
        dig_t      = bcd_r[31:28];
        dig_u      = bcd_r[27:24];
        later_zero = !(gnz[2] || gnz[3]);
      end
      GRP_THOUSAND: begin
        dig_h      = bcd_r[23:20];
        dig_t      = bcd_r[19:16];
        dig_u      = bcd_r[15:12];
        later_zero = !gnz[3];
      end
      default: begin
        dig_h      = bcd_r[11:8];
        dig_t      = bcd_r[7:4];
        dig_u      = bcd_r[3:0];
        later_zero = 1'b1;
      end
    endcase
  end

  always_comb begin
    word_sel = W_ZERO;
    has_word = 1'b0;
    is_last  = 1'b0;
    if (is_zero) begin
      word_sel = W_ZERO;
      has_word = 1'b1;
      is_last  = 1'b1;
    end else begin
      unique case (cmd.phase)
        PH_HUND: begin
          word_sel = {1'b0, dig_h};
          has_word = (dig_h != 4'd0);
        end
        PH_HWORD: begin
          word_sel = W_HUNDRED;
          has_word = (dig_h != 4'd0);
          is_last  = is_ones && (dig_t == 4'd0) && (dig_u == 4'd0);
        end
        PH_TENS: begin
          has_word = (dig_t != 4'd0) || (dig_u != 4'd0);
          is_last  = is_ones && ((dig_t < 4'd2) || (dig_u == 4'd0));
          if (dig_t >= 4'd2) begin
            word_sel = W_TENS_BASE + {1'b0, dig_t};
          end else if (dig_t == 4'd1) begin
            word_sel = W_TEEN_BASE + {1'b0, dig_u};
          end else begin
            word_sel = {1'b0, dig_u};
          end
        end
        PH_UNIT: begin
          word_sel = {1'b0, dig_u};
          has_word = (dig_t >= 4'd2) && (dig_u != 4'd0);
          is_last  = is_ones;
        end
        PH_SCALE: begin
          has_word = !is_ones && gnz[cmd.group];
          is_last  = later_zero;
          unique case (cmd.group)
            GRP_BILLION:  word_sel = W_BILLION;
            GRP_MILLION:  word_sel = W_MILLION;
            GRP_THOUSAND: word_sel = W_THOUSAND;
            default:      word_sel = W_ZERO;
          endcase
        end
        default: begin
          has_word = 1'b0;
        end
      endcase
    end
  end

  assign status.has_word = has_word;
  assign status.is_last  = is_last;
  assign out_word        = out_word_r;
  assign out_last        = out_last_r;

endmodule

// File: rtl/i2wt_ctrl.sv
// ----------------------------------------------------------------------------
// Integer to word tokens controller
// Sequences conversion, walks the groups and phases and owns output valid.
// ----------------------------------------------------------------------------
module i2wt_ctrl
  import i2wt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  i2wt_status_t  status,
  output i2wt_cmd_t     cmd
);

  ctl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       group_r, group_nxt;
  phase_t           phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             can_load;
  logic             advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      group_r     <= GRP_BILLION;
      phase_r     <= PH_HUND;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      group_r     <= group_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign can_load = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    group_nxt     = group_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    advance       = 1'b0;
    cmd.start     = 1'b0;
    cmd.shift     = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.group     = group_r;
    cmd.phase     = phase_r;

    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (cnt_r == CNT_W'(VALUE_W - 1)) begin
          group_nxt = GRP_BILLION;
          phase_nxt = PH_HUND;
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (status.has_word) begin
          if (can_load) begin
            cmd.load_out  = 1'b1;
            out_valid_nxt = 1'b1;
            if (status.is_last) begin
              state_nxt = ST_IDLE;
            end else begin
              advance = 1'b1;
            end
          end
        end else begin
          advance = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (advance) begin
      unique case (phase_r)
        PH_HUND:  phase_nxt = PH_HWORD;
        PH_HWORD: phase_nxt = PH_TENS;
        PH_TENS:  phase_nxt = PH_UNIT;
        PH_UNIT:  phase_nxt = PH_SCALE;
        PH_SCALE: begin
          phase_nxt = PH_HUND;
          group_nxt = group_r + 1'b1;
        end
        default:  phase_nxt = PH_HUND;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/integer_to_word_tokens.sv
// ----------------------------------------------------------------------------
// Integer to word tokens
// Spells a 31-bit unsigned integer as a run of English word codes.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  in_value[30:0]
//   out      out_valid/ out_stall out_word[4:0], out_last
//
// Each number is taken and converted by shift-and-add-three decimal
// conversion, then up to 19 group phases are walked while its words are sent.
// A new number is taken only once the last word of the one before is loaded.
// The output register lets the next number be taken while the final word
// still waits. A stall on the output holds the phase walk at the pending word.
// Reset is synchronous and active low; it leaves the block idle and empty.
// ----------------------------------------------------------------------------
module integer_to_word_tokens
  import i2wt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [VALUE_W-1:0]  in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WORD_W-1:0]   out_word,
  output logic                out_last
);

  i2wt_cmd_t    cmd;
  i2wt_status_t status;

  i2wt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  i2wt_datapath u_datapath (
    .clk      (clk),
    .in_value (in_value),
    .cmd      (cmd),
    .status   (status),
    .out_word (out_word),
    .out_last (out_last)
  );

`include "integer_to_word_tokens_assert.svh"

  `I2WT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `I2WT_ASSERT_SAME(a_zero_is_last, out_valid && (out_word == W_ZERO), out_last)
  `I2WT_ASSERT_SAME(a_more_words_busy, out_valid && !out_last, in_stall)
  `I2WT_ASSERT_SAME(a_load_needs_room, cmd.load_out, !out_valid || !out_stall)

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Integer to word tokens testbench
// Sends directed and random integers to the block and compares every word
// transfer with a spelling predicted inside the bench. The input idles and
// the output stalls at random; at times the sender pauses until drained.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import i2wt_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int TAIL_CYCLES  = 100;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [WORD_W-1:0]  word;
    logic               last;
  } token_t;

  class spelling_board;
    token_t             expected_words[$];
    token_t             spelled[$];
    logic [VALUE_W-1:0] current;
    int unsigned        numbers;
    int unsigned        words_seen;
    int unsigned        errors;
    int unsigned        longest;

    function void put_word(logic [WORD_W-1:0] w);
      token_t t;
      t.value = current;
      t.word  = w;
      t.last  = 1'b0;
      spelled.push_back(t);
    endfunction

    function void spell_group(int unsigned g);
      int unsigned rest;
      rest = g % 100;
      if (g >= 100) begin
        put_word(WORD_W'(g / 100));
        put_word(W_HUNDRED);
      end
      if (rest >= 20) begin
        put_word(W_TENS_BASE + WORD_W'(rest / 10));
        if (rest % 10 != 0) put_word(WORD_W'(rest % 10));
      end else if (rest >= 10) begin
        put_word(W_TEEN_BASE + WORD_W'(rest - 10));
      end else if (rest != 0) begin
        put_word(WORD_W'(rest));
      end
    endfunction

    function void note_value(logic [VALUE_W-1:0] v);
      int unsigned n;
      n = v;
      current = v;
      spelled.delete();
      if (n == 0) begin
        put_word(W_ZERO);
      end else begin
        if (n >= 1000000000) begin
          spell_group(n / 1000000000);
          put_word(W_BILLION);
        end
        if ((n / 1000000) % 1000 != 0) begin
          spell_group((n / 1000000) % 1000);
          put_word(W_MILLION);
        end
        if ((n / 1000) % 1000 != 0) begin
          spell_group((n / 1000) % 1000);
          put_word(W_THOUSAND);
        end
        spell_group(n % 1000);
      end
      spelled[spelled.size() - 1].last = 1'b1;
      if (spelled.size() > longest) longest = spelled.size();
      numbers++;
      foreach (spelled[i]) expected_words.push_back(spelled[i]);
    endfunction

    function void check_word(logic [WORD_W-1:0] w, logic l);
      token_t t;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word transfer: expected none, got word %0d last %0b",
                 $time, w, l);
        return;
      end
      t = expected_words.pop_front();
      words_seen++;
      if (w !== t.word) begin
        errors++;
        $display("%0t: word mismatch for value %0d: expected %0d, got %0d",
                 $time, t.value, t.word, w);
      end
      if (l !== t.last) begin
        errors++;
        $display("%0t: last mismatch for value %0d: expected %0b, got %0b",
                 $time, t.value, t.last, l);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic [VALUE_W-1:0] in_value  = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [WORD_W-1:0]  out_word;
  logic               out_last;

  spelling_board board = new;
  logic          quiet = 1'b0;
  int            stall_left = 0;
  int            cycles = 0;
  int            directed_count = 0;

  integer_to_word_tokens uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .out_last  (out_last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic int unsigned pick_group();
    int r;
    r = $urandom_range(0, 7);
    if (r < 2) return 0;
    if (r < 4) return $urandom_range(1, 99);
    return $urandom_range(0, 999);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    int          r;
    int unsigned b, m, t, o;
    r = $urandom_range(0, 9);
    if (r < 2) return VALUE_W'($urandom);
    if (r < 3) return VALUE_W'($urandom_range(0, 999));
    m = pick_group();
    t = pick_group();
    o = pick_group();
    b = $urandom_range(0, 2);
    if (b == 2 && m * 1000000 + t * 1000 + o > 147483647) b = 1;
    return VALUE_W'(b * 1000000000 + m * 1000000 + t * 1000 + o);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 5) == 0) stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_word(out_word, out_last);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.",
               cycles, board.expected_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_value(input logic [VALUE_W-1:0] v);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    board.note_value(v);
  endtask

  task automatic idle_gap();
    int n;
    n = quiet ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      in_value <= VALUE_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [VALUE_W-1:0] directed[$];
    directed = '{0, 1, 9, 10, 12, 19, 20, 21, 90, 99, 100, 101, 110, 999, 1000,
                 1001, 1000000, 1000000000, 1000000001, 1010010010, 700000000,
                 999999999, 1073741824, 1777777777, 2147483647};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) begin
      push_value(directed[i]);
      directed_count++;
      idle_gap();
    end
    drain_results();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) quiet <= ($urandom_range(0, 2) == 0);
      push_value(random_value());
      if (i == RANDOM_ITEMS / 2) drain_results();
      else idle_gap();
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Spelled %0d numbers (%0d edge values, rest random) as %0d word transfers;",
             board.numbers, directed_count, board.words_seen);
    $display("longest spelling %0d words, under random idle and stall on both channels.",
             board.longest);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
